/* rtl/swms_pkg.sv */
// Package for the sliding-window mean / standard deviation block.
// Holds sizes, the controller state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none
package swms_pkg;
    localparam int CHANNELS   = 14;
    localparam int MAX_WINDOW = 32;
    localparam int CH_W       = 4;
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int ADDR_W     = $clog2(CHANNELS * MAX_WINDOW);
    localparam int DEPTH      = CHANNELS * MAX_WINDOW;
    localparam int WL_W       = 6;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 24;
    localparam int SUM_W      = 22;   // sum of 32 samples
    localparam int DIFF_W     = 26;   // |256*x - mean| < 2^25
    localparam int SQ_W       = 50;   // diff^2
    localparam int SSQ_W      = 56;   // sum of 32 squares
    localparam int DIV_W      = 56;   // dividend width for the shared divider
    localparam int CNT_W      = $clog2(DIV_W + 1);
    localparam logic [WL_W-1:0] WL_RESET = WL_W'(32);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_STORE,
        ST_SUM,
        ST_MDIV,
        ST_SQ,
        ST_VDIV,
        ST_SQRT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;        // write zero at clear address, advance it
        logic load;         // latch the input transfer
        logic store;        // write sample, set window
        logic acc_sum;      // read/accumulate one sample for the sum
        logic mdiv_start;
        logic mdiv_step;
        logic acc_sq;       // read/accumulate one squared deviation
        logic vdiv_start;
        logic vdiv_step;
        logic sqrt_start;
        logic sqrt_step;
        logic finish;       // latch result into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic bad_channel;
        logic walk_done;    // last sample of the window issued
        logic pipe_empty;   // read pipeline drained
        logic div_done;
        logic sqrt_done;
    } status_t;
endpackage
`default_nettype wire

/* rtl/swms_if.sv */
// Valid/ready channel interfaces for the input and result transfers.
// Depends on swms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface swms_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [swms_pkg::CH_W-1:0]              channel;
    logic signed [swms_pkg::SAMPLE_W-1:0]   sample;
    modport source (output valid, channel, sample, input ready);
    modport sink (input valid, channel, sample, output ready);
endinterface

interface swms_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [swms_pkg::OUT_W-1:0]      window_mean;
    logic [swms_pkg::OUT_W-1:0]             window_sd;
    modport source (output valid, window_mean, window_sd, input ready);
    modport sink (input valid, window_mean, window_sd, output ready);
endinterface
`default_nettype wire

/* rtl/swms_ctrl.sv */
// Controller state machine for the sliding-window statistics block.
// Depends on swms_pkg (state_t, cmd_t, status_t).
`timescale 1ns / 1ps
`default_nettype none
module swms_ctrl (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire                      out_ready,
    input  swms_pkg::status_t        status,
    output swms_pkg::cmd_t           cmd
);
    swms_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= swms_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swms_pkg::ST_CLEAR: if (status.clear_done) state_next = swms_pkg::ST_IDLE;
            swms_pkg::ST_IDLE:  if (in_valid) state_next = swms_pkg::ST_STORE;
            swms_pkg::ST_STORE:
                state_next = status.bad_channel ? swms_pkg::ST_OUT : swms_pkg::ST_SUM;
            swms_pkg::ST_SUM:
                if (status.walk_done && status.pipe_empty) state_next = swms_pkg::ST_MDIV;
            swms_pkg::ST_MDIV:  if (status.div_done) state_next = swms_pkg::ST_SQ;
            swms_pkg::ST_SQ:
                if (status.walk_done && status.pipe_empty) state_next = swms_pkg::ST_VDIV;
            swms_pkg::ST_VDIV:  if (status.div_done) state_next = swms_pkg::ST_SQRT;
            swms_pkg::ST_SQRT:  if (status.sqrt_done) state_next = swms_pkg::ST_OUT;
            swms_pkg::ST_OUT:   if (!out_valid || out_ready) state_next = swms_pkg::ST_IDLE;
            default:            state_next = swms_pkg::ST_IDLE;
        endcase
    end

    logic out_valid_reg;
    assign out_valid = out_valid_reg;

    // output register handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            swms_pkg::ST_CLEAR: cmd.clear = 1'b1;
            swms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            swms_pkg::ST_STORE: cmd.store = 1'b1;
            swms_pkg::ST_SUM:
            begin
                cmd.acc_sum = 1'b1;
                cmd.mdiv_start = status.walk_done && status.pipe_empty;
            end
            swms_pkg::ST_MDIV:  cmd.mdiv_step = 1'b1;
            swms_pkg::ST_SQ:
            begin
                cmd.acc_sq = 1'b1;
                cmd.vdiv_start = status.walk_done && status.pipe_empty;
            end
            swms_pkg::ST_VDIV:
            begin
                cmd.vdiv_step = 1'b1;
                cmd.sqrt_start = status.div_done;
            end
            swms_pkg::ST_SQRT:  cmd.sqrt_step = 1'b1;
            swms_pkg::ST_OUT:   cmd.finish = !out_valid || out_ready;
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/swms_dp.sv */
// Datapath: sample memory, ring pointers, accumulators, shared divider, square root.
// Depends on swms_pkg (sizes, cmd_t, status_t).
`timescale 1ns / 1ps
`default_nettype none
module swms_dp (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire  [swms_pkg::WL_W-1:0]           window_length,
    input  wire  [swms_pkg::CH_W-1:0]           in_channel,
    input  wire  signed [swms_pkg::SAMPLE_W-1:0] in_sample,
    input  swms_pkg::cmd_t                      cmd,
    output swms_pkg::status_t                   status,
    output logic signed [swms_pkg::OUT_W-1:0]   window_mean,
    output logic [swms_pkg::OUT_W-1:0]          window_sd
);
    localparam int PW = swms_pkg::POS_W;
    localparam int AW = swms_pkg::ADDR_W;

    // sample memory
    logic [swms_pkg::SAMPLE_W-1:0] mem [swms_pkg::DEPTH];
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [swms_pkg::SAMPLE_W-1:0] mem_wdata, mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    // per-channel newest position
    logic [PW-1:0] pos_reg [swms_pkg::CHANNELS];
    logic [AW-1:0] clr_addr_reg;
    logic [swms_pkg::CH_W-1:0] ch_reg;
    logic signed [swms_pkg::SAMPLE_W-1:0] smp_reg;
    logic bad;
    logic [PW-1:0] newpos;
    logic [AW-1:0] base;

    assign bad    = 32'(ch_reg) >= swms_pkg::CHANNELS;
    assign newpos = pos_reg[ch_reg[swms_pkg::CH_W-1:0]] + PW'(1);
    assign base   = AW'(ch_reg) * AW'(swms_pkg::MAX_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < swms_pkg::CHANNELS; i++)
                pos_reg[i] <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.store && !bad)
                pos_reg[ch_reg] <= newpos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg  <= in_channel;
            smp_reg <= in_sample;
        end
    end

    assign mem_we    = cmd.clear || (cmd.store && !bad);
    assign mem_waddr = cmd.clear ? clr_addr_reg : base + AW'(newpos);
    assign mem_wdata = cmd.clear ? '0 : smp_reg;

    // window walk: issue addresses; the memory read is registered
    logic [PW-1:0] wpos_reg;
    logic [swms_pkg::WL_W-1:0] n_reg, left_reg;
    logic rd_vld_reg;
    logic walking;
    logic [swms_pkg::WL_W-1:0] n_sat;

    assign n_sat = (window_length == '0) ? swms_pkg::WL_W'(1) :
                   (window_length > swms_pkg::WL_W'(swms_pkg::MAX_WINDOW)) ?
                   swms_pkg::WL_W'(swms_pkg::MAX_WINDOW) : window_length;
    assign walking   = (cmd.acc_sum || cmd.acc_sq) && (left_reg != '0);
    assign mem_raddr = base + AW'(wpos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= walking;
            if (cmd.store || cmd.mdiv_start)
                left_reg <= cmd.store ? n_sat : n_reg;
            else if (walking)
                left_reg <= left_reg - swms_pkg::WL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            n_reg    <= n_sat;
            wpos_reg <= newpos;
        end
        else if (cmd.mdiv_start)
            wpos_reg <= pos_reg[ch_reg];
        else if (walking)
            wpos_reg <= wpos_reg - PW'(1);
    end

    // accumulators
    logic signed [swms_pkg::SUM_W-1:0] sum_reg;
    logic [swms_pkg::SSQ_W-1:0]        ssq_reg;
    logic signed [swms_pkg::OUT_W-1:0] mean_reg;
    logic signed [swms_pkg::DIFF_W-1:0] diff;
    logic [swms_pkg::DIFF_W-1:0]       adiff_reg;
    logic                              sq_vld_reg;
    logic [swms_pkg::SQ_W-1:0]         sq_reg;
    logic                              sq2_vld_reg;

    assign diff = {{(swms_pkg::DIFF_W-swms_pkg::SAMPLE_W-8){mem_rdata_reg[swms_pkg::SAMPLE_W-1]}},
                   mem_rdata_reg, 8'h00} - swms_pkg::DIFF_W'(mean_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= 1'b0;
            sq2_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg  <= rd_vld_reg && cmd.acc_sq;
            sq2_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            sum_reg <= '0;
            ssq_reg <= '0;
        end
        else
        begin
            if (rd_vld_reg && cmd.acc_sum)
                sum_reg <= sum_reg + swms_pkg::SUM_W'($signed(mem_rdata_reg));
            if (sq2_vld_reg)
                ssq_reg <= ssq_reg + swms_pkg::SSQ_W'(sq_reg);
        end
        adiff_reg <= diff[swms_pkg::DIFF_W-1] ? -diff : diff;
        sq_reg    <= swms_pkg::SQ_W'(adiff_reg) * swms_pkg::SQ_W'(adiff_reg);
    end

    // shared restoring divider by n (unsigned magnitude)
    logic [swms_pkg::DIV_W-1:0] q_reg;
    logic [swms_pkg::WL_W:0]    r_reg;
    logic [swms_pkg::CNT_W-1:0] cnt_reg;
    logic                       neg_reg;
    logic [swms_pkg::WL_W+1:0]  r_sh;
    logic [swms_pkg::DIV_W-1:0] abs_sum;
    logic [swms_pkg::DIV_W-1:0] q_neg;

    assign abs_sum = sum_reg[swms_pkg::SUM_W-1] ?
                     swms_pkg::DIV_W'(-sum_reg) << 8 : swms_pkg::DIV_W'(sum_reg) << 8;
    assign r_sh  = {r_reg, q_reg[swms_pkg::DIV_W-1]};
    assign q_neg = -q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mdiv_start || cmd.vdiv_start)
        begin
            q_reg   <= cmd.mdiv_start ? abs_sum : ssq_reg;
            neg_reg <= cmd.mdiv_start && sum_reg[swms_pkg::SUM_W-1];
            r_reg   <= '0;
            cnt_reg <= swms_pkg::CNT_W'(swms_pkg::DIV_W);
        end
        else if ((cmd.mdiv_step || cmd.vdiv_step) && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - swms_pkg::CNT_W'(1);
            if (r_sh >= {2'b00, n_reg})
            begin
                r_reg <= (swms_pkg::WL_W+1)'(r_sh - {2'b00, n_reg});
                q_reg <= {q_reg[swms_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh[swms_pkg::WL_W:0];
                q_reg <= {q_reg[swms_pkg::DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.mdiv_step && cnt_reg == '0)
            mean_reg <= neg_reg ? swms_pkg::OUT_W'(q_neg) : swms_pkg::OUT_W'(q_reg);
    end

    // bit-pair square root of the variance (48-bit range fits in 56)
    logic [swms_pkg::SSQ_W-1:0] sv_reg, root_reg, bit_reg;
    logic [swms_pkg::SSQ_W-1:0] trial;
    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sv_reg   <= q_reg;
            root_reg <= '0;
            bit_reg  <= swms_pkg::SSQ_W'(1) << (swms_pkg::SSQ_W - 2);
        end
        else if (cmd.sqrt_step && bit_reg != '0)
        begin
            if (sv_reg >= trial)
            begin
                sv_reg   <= sv_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            window_mean <= bad ? '0 : mean_reg;
            window_sd   <= bad ? '0 : root_reg[swms_pkg::OUT_W-1:0];
        end
    end

    assign status.clear_done  = clr_addr_reg == AW'(swms_pkg::DEPTH - 1);
    assign status.bad_channel = bad;
    assign status.walk_done   = left_reg == '0;
    assign status.pipe_empty  = !rd_vld_reg && !sq_vld_reg && !sq2_vld_reg && !walking;
    assign status.div_done    = cnt_reg == '0;
    assign status.sqrt_done   = bit_reg == '0;
endmodule
`default_nettype wire

/* rtl/sliding_window_mean_stddev.sv */
// Top level: per-channel sliding-window mean and standard deviation.
// Sequence from input transfer to result valid for a valid channel: store, sum walk, mean divide,
// deviation walk, variance divide, square root, output; an invalid channel goes from store to output.
// One item in flight: a new input transfer is taken only once the previous result is in the output register.
// After reset a clearing pass zeroes all 448 sample memory entries; no input is taken then.
// Depends on swms_pkg, swms_if, swms_ctrl and swms_dp.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_mean_stddev (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [swms_pkg::WL_W-1:0]     cfg_wdata,
    swms_in_if.sink                      in_ch,
    swms_out_if.source                   out_ch
);
    logic [swms_pkg::WL_W-1:0] window_length_reg;
    swms_pkg::cmd_t    cmd;
    swms_pkg::status_t status;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_length_reg <= swms_pkg::WL_RESET;
        else if (cfg_we)
            window_length_reg <= cfg_wdata;
    end

    swms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    swms_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_length_reg),
        .in_channel    (in_ch.channel),
        .in_sample     (in_ch.sample),
        .cmd           (cmd),
        .status        (status),
        .window_mean   (out_ch.window_mean),
        .window_sd     (out_ch.window_sd)
    );
endmodule
`default_nettype wire

/* dv/tb_sliding_window_mean_stddev.sv */
// Testbench for sliding_window_mean_stddev: directed table and transfers, then random sample transfers,
// each result checked against typed-in values or a behavioral predictor of the per-channel window statistics.
// Depends on swms_pkg, swms_if and the RTL top level.
`timescale 1ns / 1ps
module tb_sliding_window_mean_stddev;
    localparam int LIMIT = 2_000_000;
    localparam int DRAIN = 400;

    typedef struct {
        logic [swms_pkg::CH_W-1:0]             channel;
        logic signed [swms_pkg::SAMPLE_W-1:0]  sample;
        bit                                    known;    // expected values typed in
        logic signed [swms_pkg::OUT_W-1:0]     mean;
        logic [swms_pkg::OUT_W-1:0]            sd;
    } row_t;

    typedef struct {
        logic signed [swms_pkg::OUT_W-1:0]  mean;
        logic [swms_pkg::OUT_W-1:0]         sd;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [swms_pkg::WL_W-1:0] cfg_wdata = '0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    // predictor state
    logic signed [swms_pkg::SAMPLE_W-1:0] hist [swms_pkg::CHANNELS][swms_pkg::MAX_WINDOW];
    logic [swms_pkg::POS_W-1:0] newest [swms_pkg::CHANNELS];
    logic [swms_pkg::WL_W-1:0] win_len;
    stats_t pending_stats[$];

    swms_in_if in_ch();
    swms_out_if out_ch();

    sliding_window_mean_stddev u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.channel = '0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // for a valid channel, store the sample and compute window mean / population deviation
    function automatic stats_t window_stats(logic [swms_pkg::CH_W-1:0] ch,
                                            logic signed [swms_pkg::SAMPLE_W-1:0] s);
        stats_t r;
        int n;
        longint sum;
        longint mean_q8;
        longint d;
        longint unsigned sumsq;
        logic [swms_pkg::POS_W-1:0] p;
        r.mean = '0;
        r.sd = '0;
        if (ch >= swms_pkg::CHANNELS)
            return r;
        newest[ch] = newest[ch] + 1'b1;
        hist[ch][newest[ch]] = s;
        n = win_len;
        if (n == 0)
            n = 1;
        if (n > swms_pkg::MAX_WINDOW)
            n = swms_pkg::MAX_WINDOW;
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            p = newest[ch] - swms_pkg::POS_W'(i);
            sum += longint'(hist[ch][p]);
        end
        mean_q8 = (sum * 256) / n;
        sumsq = 0;
        for (int i = 0; i < n; i++)
        begin
            p = newest[ch] - swms_pkg::POS_W'(i);
            d = longint'(hist[ch][p]) * 256 - mean_q8;
            if (d < 0)
                d = -d;
            sumsq += longint'(d) * longint'(d);
        end
        r.mean = mean_q8[swms_pkg::OUT_W-1:0];
        r.sd = swms_pkg::OUT_W'(int_sqrt(sumsq / n));
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            stats_t e;
            if (pending_stats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result mean=%0d sd=%0d", $time,
                         out_ch.window_mean, out_ch.window_sd);
            end
            else
            begin
                e = pending_stats.pop_front();
                if (out_ch.window_mean !== e.mean)
                begin
                    errors++;
                    $display("%0t: window_mean expected %0d actual %0d", $time,
                             e.mean, out_ch.window_mean);
                end
                if (out_ch.window_sd !== e.sd)
                begin
                    errors++;
                    $display("%0t: window_sd expected %0d actual %0d", $time,
                             e.sd, out_ch.window_sd);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("sliding_window_mean_stddev: mismatch");
            $finish;
        end
    end

    task automatic write_window(logic [swms_pkg::WL_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        win_len = v;
    endtask

    // drop valid, then wait for every outstanding result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // one input transfer; the expectation is queued at acceptance
    task automatic send_sample(logic [swms_pkg::CH_W-1:0] ch,
                               logic signed [swms_pkg::SAMPLE_W-1:0] s,
                               bit known, stats_t given);
        stats_t e;
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.channel <= ch;
        in_ch.sample <= s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        e = window_stats(ch, s);
        if (known)
            e = given;
        pending_stats.push_back(e);
        @(negedge clk);
    endtask

    task automatic random_phase(int count, int unsigned idle, int unsigned stall);
        stats_t none;
        logic [swms_pkg::CH_W-1:0] ch;
        logic signed [swms_pkg::SAMPLE_W-1:0] s;
        none = '{default: '0};
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            ch = ($urandom_range(19) == 0) ?
                 swms_pkg::CH_W'($urandom_range(15, swms_pkg::CHANNELS)) :
                 swms_pkg::CH_W'($urandom_range(swms_pkg::CHANNELS - 1));
            case ($urandom_range(4))
                0: s = ($urandom_range(1)) ? 16'sh7fff : -16'sh8000;
                1: s = swms_pkg::SAMPLE_W'($urandom_range(200)) - 16'sd100;
                default: s = swms_pkg::SAMPLE_W'($urandom);
            endcase
            send_sample(ch, s, 1'b0, none);
        end
    endtask

    row_t dir_rows [11] = '{
        '{4'd0, 16'sd0, 1'b1, 24'sd0, 24'd0},
        '{4'd14, 16'sd1234, 1'b1, 24'sd0, 24'd0},
        '{4'd15, -16'sd1, 1'b1, 24'sd0, 24'd0},
        '{4'd13, 16'sh7fff, 1'b0, 24'sd0, 24'd0},
        '{4'd13, -16'sh8000, 1'b0, 24'sd0, 24'd0},
        '{4'd1, -16'sh8000, 1'b0, 24'sd0, 24'd0},
        '{4'd1, 16'sh7fff, 1'b0, 24'sd0, 24'd0},
        '{4'd2, 16'sd1, 1'b0, 24'sd0, 24'd0},
        '{4'd2, -16'sd1, 1'b0, 24'sd0, 24'd0},
        '{4'd7, 16'sh5555, 1'b0, 24'sd0, 24'd0},
        '{4'd8, -16'sh5556, 1'b0, 24'sd0, 24'd0}
    };

    initial
    begin
        stats_t given;
        for (int c = 0; c < swms_pkg::CHANNELS; c++)
        begin
            newest[c] = '0;
            for (int k = 0; k < swms_pkg::MAX_WINDOW; k++)
                hist[c][k] = '0;
        end
        win_len = swms_pkg::WL_RESET;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed table at reset window length
        foreach (dir_rows[i])
        begin
            given.mean = dir_rows[i].mean;
            given.sd = dir_rows[i].sd;
            send_sample(dir_rows[i].channel, dir_rows[i].sample, dir_rows[i].known, given);
        end
        wait_drained();

        // window length one: result mean is the sample scaled by 256, with zero deviation
        write_window(6'd1);
        given.mean = 24'sh800000;
        given.sd = 24'd0;
        send_sample(4'd3, -16'sh8000, 1'b1, given);
        given.mean = 24'sh7fff00;
        send_sample(4'd3, 16'sh7fff, 1'b1, given);
        wait_drained();

        // zero is treated as one, above 32 saturates
        write_window(6'd0);
        random_phase(40, 0, 0);
        wait_drained();
        write_window(6'd63);
        random_phase(80, 0, 0);
        wait_drained();
        write_window(6'd33);
        random_phase(60, 0, 0);

        // sender pauses until everything has come back; then runs with sender idles and receiver stalls
        wait_drained();
        write_window(6'd32);
        random_phase(400, 0, 0);
        wait_drained();
        write_window(6'd5);
        random_phase(300, 47, 0);
        wait_drained();
        write_window(6'd17);
        random_phase(300, 0, 47);
        wait_drained();
        write_window(6'd2);
        random_phase(200, 18, 18);
        wait_drained();
        write_window(6'd31);
        random_phase(200, 18, 18);
        wait_drained();

        if (errors == 0)
            $display("sliding_window_mean_stddev: match");
        else
            $display("sliding_window_mean_stddev: mismatch");
        $finish;
    end
endmodule

/* files.f */
rtl/swms_pkg.sv
rtl/swms_if.sv
rtl/swms_ctrl.sv
rtl/swms_dp.sv
rtl/sliding_window_mean_stddev.sv
dv/tb_sliding_window_mean_stddev.sv
